// File: design/assert_macros.svh
// Assertion helpers; all assume a clock named clk and an active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: design/hve_pkg.sv
package hve_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH0    = 3'd0,
    PH_SEARCH1    = 3'd1,
    PH_SEARCH2    = 3'd2,
    PH_SEARCH3    = 3'd3,
    PH_AFTER_NAME = 3'd4,
    PH_AFTER_EQ   = 3'd5,
    PH_QUOTED     = 3'd6,
    PH_UNQUOTED   = 3'd7
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   quote_single;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       value_end;
  } step_res_t;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_EOD  = 1'b1;

  localparam parse_state_t STATE_RESET = '{phase: PH_SEARCH0, quote_single: 1'b0};

endpackage

// File: design/hve_step.sv
module hve_step
  import hve_pkg::*;
(
  input  parse_state_t state,
  input  logic         cmd,
  input  logic [7:0]   text_byte,
  output parse_state_t state_nxt,
  output step_res_t    res
);

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_H  = 8'h68;

  function automatic logic [7:0] name_letter(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h68;
      2'd1:    c = 8'h72;
      2'd2:    c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) r = b + 8'd32;
    return r;
  endfunction

  // k letters matched; a full match lands on PH_AFTER_NAME
  function automatic phase_t search_step(input logic [1:0] k, input logic [7:0] b);
    logic [7:0] lb;
    phase_t     p;
    lb = lower_ascii(b);
    if (lb == name_letter(k)) p = phase_t'({1'b0, k} + 3'd1);
    else if (lb == CH_H)      p = PH_SEARCH1;
    else                      p = PH_SEARCH0;
    return p;
  endfunction

  logic [7:0] close_quote;

  assign close_quote = state.quote_single ? CH_SQ : CH_DQ;

  always_comb begin
    state_nxt = state;
    res       = '0;
    if (cmd == CMD_EOD) begin
      state_nxt = STATE_RESET;
      if (state.phase == PH_QUOTED || state.phase == PH_UNQUOTED) begin
        res.valid     = 1'b1;
        res.value_end = 1'b1;
      end
    end else begin
      case (state.phase)
        PH_AFTER_NAME: begin
          if (text_byte == CH_EQ) state_nxt.phase = PH_AFTER_EQ;
          else if (!is_ws(text_byte)) state_nxt.phase = search_step(2'd0, text_byte);
        end
        PH_AFTER_EQ: begin
          if (is_ws(text_byte)) begin
            state_nxt.phase = PH_AFTER_EQ;
          end else if (text_byte == CH_DQ || text_byte == CH_SQ) begin
            state_nxt.phase        = PH_QUOTED;
            state_nxt.quote_single = (text_byte == CH_SQ);
          end else if (text_byte == CH_GT) begin
            state_nxt.phase = PH_SEARCH0;
            res.valid       = 1'b1;
            res.value_end   = 1'b1;
          end else begin
            state_nxt.phase = PH_UNQUOTED;
            res.valid       = 1'b1;
            res.has_byte    = 1'b1;
            res.value_byte  = text_byte;
          end
        end
        PH_QUOTED: begin
          res.valid = 1'b1;
          if (text_byte == close_quote) begin
            state_nxt.phase = PH_SEARCH0;
            res.value_end   = 1'b1;
          end else begin
            res.has_byte   = 1'b1;
            res.value_byte = text_byte;
          end
        end
        PH_UNQUOTED: begin
          res.valid = 1'b1;
          // terminator cannot start a name, so it drops straight to search
          if (is_ws(text_byte) || text_byte == CH_GT) begin
            state_nxt.phase = PH_SEARCH0;
            res.value_end   = 1'b1;
          end else begin
            res.has_byte   = 1'b1;
            res.value_byte = text_byte;
          end
        end
        default: begin
          state_nxt.phase = search_step(state.phase[1:0], text_byte);
        end
      endcase
    end
  end

endmodule

// File: design/href_value_extractor.sv
// href value extractor
// Input channel: in_valid/in_ready with in_cmd and in_text_byte. in_cmd low
// carries one document byte; in_cmd high marks end of document, closes any
// open value with an end mark and returns the parser to its search state.
// Output channel: out_valid/out_ready with out_value_byte, out_has_byte and
// out_value_end. Each value byte is one transaction with out_has_byte set;
// the end of each value (even an empty one) is one transaction with
// out_value_end set. Bytes outside values give no transaction.
// An accepted byte lands in the input register, is parsed there and its
// result, if any, is then registered in and shown from the output register.
// Throughput: one byte per cycle while in_ready is high; the state update
// per byte is a single pass of parser logic between input and output registers.
// A stalled receiver holds the output register; the input register still
// drains bytes that give no result, and in_ready drops only while both
// registers are full, the held byte gives a result and out_ready is low.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// in its search state with nothing matched.
`include "assert_macros.svh"

module href_value_extractor
  import hve_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_value_byte,
  output logic       out_has_byte,
  output logic       out_value_end
);

  logic         s0_valid_r;
  logic         s0_cmd_r;
  logic [7:0]   s0_byte_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  step_res_t    res;
  logic         out_valid_r;
  logic [7:0]   out_value_byte_r;
  logic         out_has_byte_r;
  logic         out_value_end_r;
  logic         out_free;
  logic         s0_adv;

  hve_step u_step (
    .state     (state_r),
    .cmd       (s0_cmd_r),
    .text_byte (s0_byte_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  assign out_free = !out_valid_r || out_ready;
  // items that give no result need no room in the output register
  assign s0_adv   = s0_valid_r && (out_free || !res.valid);
  assign in_ready = !s0_valid_r || s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_ready) s0_valid_r <= in_valid;
      if (s0_adv) state_r <= state_nxt;
      if (out_free) out_valid_r <= s0_adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_cmd_r  <= in_cmd;
      s0_byte_r <= in_text_byte;
    end
    if (out_free && s0_adv && res.valid) begin
      out_value_byte_r <= res.value_byte;
      out_has_byte_r   <= res.has_byte;
      out_value_end_r  <= res.value_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_byte = out_value_byte_r;
  assign out_has_byte   = out_has_byte_r;
  assign out_value_end  = out_value_end_r;

  `ASSERT_IMPL(a_one_kind, out_valid_r, out_has_byte_r != out_value_end_r)
  `ASSERT_NEXT(a_eod_resets, s0_adv && s0_cmd_r == CMD_EOD,
               state_r.phase == PH_SEARCH0 && !state_r.quote_single)
  `ASSERT_IMPL(a_byte_in_value, s0_adv && res.valid && res.has_byte,
               state_r.phase == PH_AFTER_EQ || state_r.phase == PH_QUOTED ||
               state_r.phase == PH_UNQUOTED)
  `ASSERT_IMPL(a_stall_only_full, !in_ready,
               s0_valid_r && out_valid_r && !out_ready && res.valid)

endmodule
